FILE: src/stereo_projection_error_jacobian_unit_defines.svh
// assertion macros used by the checker file
`ifndef STEREO_PROJECTION_ERROR_JACOBIAN_UNIT_DEFINES_SVH
`define STEREO_PROJECTION_ERROR_JACOBIAN_UNIT_DEFINES_SVH

// checked outside reset only
`define SPEJ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spej assertion failed");

// checked at every edge, reset included
`define SPEJ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("spej assertion failed");

`endif

FILE: src/spej_pkg.sv
// package: widths, stage counts, types and helpers of the stereo projection unit
`default_nettype none
package spej_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int FOC_W     = 31;
  localparam int FUX_W     = FOC_W + W;            // focal times magnitude
  localparam int XR_W      = 2 * W - 1;            // magnitude of x - w*baseline
  localparam int XRS_W     = XR_W + 2;             // signed form of it
  localparam int PRH_W     = FOC_W + XR_W - W;     // high partial product
  localparam int NUM_W     = FOC_W + XR_W;         // widest dividend
  localparam int DEN_W     = 2 * W - 1;            // widest divisor (z squared)
  localparam int PROJ_LOG  = 40;                   // projection clamp 2^40
  localparam int QUO_W     = PROJ_LOG + 1;         // quotient bits before rounding
  localparam int PV_W      = QUO_W + 2;            // signed clamped projection
  localparam int ERR_W     = PV_W + 2;             // error before saturation

  localparam int FRONT_STG = 4;
  localparam int DIV_STG   = QUO_W + 1;
  localparam int BACK_STG  = 3;
  localparam int NSTG      = FRONT_STG + DIV_STG + BACK_STG;

  localparam int NQ   = 8;
  localparam int NP   = 3;
  localparam int Q_PU  = 0;
  localparam int Q_PV  = 1;
  localparam int Q_PR  = 2;
  localparam int Q_JFU = 3;
  localparam int Q_JFV = 4;
  localparam int Q_JLU = 5;
  localparam int Q_JVD = 6;
  localparam int Q_JRD = 7;

  localparam int CFG_IDX_W = 3;
  localparam logic [FOC_W-1:0] FOCAL_ONE = FOC_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_U  = 3'd0,
    REG_FOCAL_V  = 3'd1,
    REG_CENTER_U = 3'd2,
    REG_CENTER_V = 3'd3,
    REG_BASELINE = 3'd4
  } cfg_idx_t;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;

  typedef struct packed {
    logic [FOC_W-1:0]    focal_u;
    logic [FOC_W-1:0]    focal_v;
    logic signed [W-1:0] center_u;
    logic signed [W-1:0] center_v;
    logic signed [W-1:0] baseline;
  } cfg_t;

  typedef struct packed {
    logic signed [W-1:0] ul;
    logic signed [W-1:0] vl;
    logic signed [W-1:0] ur;
    logic signed [W-1:0] vr;
  } meas_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zn;
    logic zero;
  } flag_t;

  typedef struct packed {
    meas_t           meas;
    logic            zero;
    logic [NQ-1:0]   neg;
  } side_t;

  function automatic logic [W-1:0] mag32(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [ERR_W-1:0] v);
    logic signed [ERR_W-1:0] hi;
    logic signed [ERR_W-1:0] lo;
    hi = ERR_W'(2147483647);
    lo = -ERR_W'(64'sd2147483648);
    if (v > hi) return W'(hi);
    if (v < lo) return W'(lo);
    return W'(v);
  endfunction

endpackage
`default_nettype wire

FILE: src/stereo_projection_error_jacobian_unit.sv
// top level: stereo pinhole projection error and camera Jacobian pipeline
//
//   channel | dir | handshake               | word
//   --------+-----+-------------------------+-------------------------------------
//   in_     | in  | in_tvalid / in_tready   | point x,y,z,w then meas ul,vl,ur,vr
//   out_    | out | out_tvalid / out_tready | four errors, five Jacobian entries
//   cfg_    | in  | cfg_valid / cfg_ready   | register index and 32-bit data
//
// one word per cycle while out_tready does not hold results back; 4 front, 42 divider and 3 back stages
// the depth is set by the restoring dividers, one quotient bit per stage
// every stage holds when the stage after it is full and stalled, so bubbles
// close up and the input keeps flowing while a result waits at the output, until the pipe is full
// rst_n (synchronous) clears the valid bits and resets the configuration registers (unit focals, zero rest)
`default_nettype none
module stereo_projection_error_jacobian_unit import spej_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input word: point_x, point_y, point_z, point_w, meas_ul, meas_vl, meas_ur, meas_vr
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [8*W-1:0]        in_tdata,
  // output word: err_ul, err_vl, err_ur, err_vr, jac_fu_over_z, jac_fv_over_z,
  //   jac_left_u_dz, jac_v_dz, jac_right_u_dz
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [9*W-1:0]        out_tdata,
  // output user: zero_depth
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [W-1:0]          cfg_data
);

  cfg_t cfg;

  spej_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // stage valid bits and per-stage load enables
  logic [NSTG-1:0] v_r, v_nxt, ld;
  logic [NSTG-1:0] v_in;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign v_in  = {v_r[NSTG-2:0], in_tvalid};
  assign v_nxt = (ld & v_in) | (~ld & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[NSTG-1];

  // input word unpacking
  meas_t meas_in;
  assign meas_in.ul = $signed(in_tdata[4*W +: W]);
  assign meas_in.vl = $signed(in_tdata[5*W +: W]);
  assign meas_in.ur = $signed(in_tdata[6*W +: W]);
  assign meas_in.vr = $signed(in_tdata[7*W +: W]);

  num_t [NQ-1:0] num;
  den_t [NQ-1:0] den;
  side_t         side_f;

  spej_front u_front (
    .clk     (clk),
    .ld      (ld[FRONT_STG-1:0]),
    .cfg     (cfg),
    .point_x ($signed(in_tdata[0*W +: W])),
    .point_y ($signed(in_tdata[1*W +: W])),
    .point_z ($signed(in_tdata[2*W +: W])),
    .point_w ($signed(in_tdata[3*W +: W])),
    .meas    (meas_in),
    .num_o   (num),
    .den_o   (den),
    .side_o  (side_f)
  );

  // eight quotients in parallel dividers
  logic [NQ-1:0][QUO_W-1:0] q;
  den_t [NQ-1:0]            rem, dq;
  logic [NQ-1:0]            ovf;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    spej_div u_div (
      .clk   (clk),
      .ld    (ld[FRONT_STG +: DIV_STG]),
      .num_i (num[i]),
      .den_i (den[i]),
      .q_o   (q[i]),
      .rem_o (rem[i]),
      .den_o (dq[i]),
      .ovf_o (ovf[i])
    );
  end

  // measurements and sign flags ride alongside the dividers
  side_t side_r [DIV_STG];

  for (genvar j = 0; j < DIV_STG; j++) begin : g_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ld[FRONT_STG]) side_r[0] <= side_f;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (ld[FRONT_STG+j]) side_r[j] <= side_r[j-1];
      end
    end
  end

  logic signed [W-1:0] err_ul, err_vl, err_ur, err_vr;
  logic signed [W-1:0] jac_fu_over_z, jac_fv_over_z;
  logic signed [W-1:0] jac_left_u_dz, jac_v_dz, jac_right_u_dz;
  logic                zero_depth;

  spej_back u_back (
    .clk            (clk),
    .ld             (ld[FRONT_STG+DIV_STG +: BACK_STG]),
    .cfg            (cfg),
    .q_i            (q),
    .rem_i          (rem),
    .den_i          (dq),
    .ovf_i          (ovf),
    .side_i         (side_r[DIV_STG-1]),
    .err_ul         (err_ul),
    .err_vl         (err_vl),
    .err_ur         (err_ur),
    .err_vr         (err_vr),
    .jac_fu_over_z  (jac_fu_over_z),
    .jac_fv_over_z  (jac_fv_over_z),
    .jac_left_u_dz  (jac_left_u_dz),
    .jac_v_dz       (jac_v_dz),
    .jac_right_u_dz (jac_right_u_dz),
    .zero_depth     (zero_depth)
  );

  assign out_tdata = {jac_right_u_dz, jac_v_dz, jac_left_u_dz, jac_fv_over_z,
                      jac_fu_over_z, err_vr, err_ur, err_vl, err_ul};
  assign out_tuser = zero_depth;

endmodule
`default_nettype wire

FILE: src/spej_cfg.sv
// configuration register file
`default_nettype none
module spej_cfg import spej_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_data,
  output cfg_t                 cfg_o
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_u  <= FOCAL_ONE;
      cfg_r.focal_v  <= FOCAL_ONE;
      cfg_r.center_u <= '0;
      cfg_r.center_v <= '0;
      cfg_r.baseline <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FOCAL_U:  cfg_r.focal_u  <= cfg_data[FOC_W-1:0];
        REG_FOCAL_V:  cfg_r.focal_v  <= cfg_data[FOC_W-1:0];
        REG_CENTER_U: cfg_r.center_u <= $signed(cfg_data);
        REG_CENTER_V: cfg_r.center_v <= $signed(cfg_data);
        REG_BASELINE: cfg_r.baseline <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/spej_front.sv
// front stages: magnitudes, products and the right-camera numerator
`default_nettype none
module spej_front import spej_pkg::*; (
  input  logic                  clk,
  input  logic [FRONT_STG-1:0]  ld,
  input  cfg_t                  cfg,
  input  logic signed [W-1:0]   point_x,
  input  logic signed [W-1:0]   point_y,
  input  logic signed [W-1:0]   point_z,
  input  logic signed [W-1:0]   point_w,
  input  meas_t                 meas,
  output num_t [NQ-1:0]         num_o,
  output den_t [NQ-1:0]         den_o,
  output side_t                 side_o
);

  // stage 1
  logic [FUX_W-1:0]        fux1_r, fvy1_r;
  logic signed [2*W-1:0]   wb1_r;
  logic signed [W-1:0]     x1_r;
  logic [W-1:0]            az1_r;
  den_t                    zsq1_r;
  flag_t                   fl1_r;
  meas_t                   ms1_r;
  logic [W-1:0]            ax, ay, az;

  assign ax = mag32(point_x);
  assign ay = mag32(point_y);
  assign az = mag32(point_z);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      fux1_r     <= FUX_W'(cfg.focal_u) * FUX_W'(ax);
      fvy1_r     <= FUX_W'(cfg.focal_v) * FUX_W'(ay);
      wb1_r      <= (2*W)'(point_w) * (2*W)'(cfg.baseline);
      x1_r       <= point_x;
      az1_r      <= az;
      zsq1_r     <= DEN_W'(az) * DEN_W'(az);
      fl1_r.xneg <= point_x[W-1];
      fl1_r.yneg <= point_y[W-1];
      fl1_r.zn   <= point_z[W-1];
      fl1_r.zero <= (point_z == '0);
      ms1_r      <= meas;
    end
  end

  // stage 2: x - w*baseline at 2F fraction bits
  logic signed [XRS_W-1:0] xr;
  logic [XR_W-1:0]         axr2_r;
  logic                    xrneg2_r;
  logic [FUX_W-1:0]        fux2_r, fvy2_r;
  logic [W-1:0]            az2_r;
  den_t                    zsq2_r;
  flag_t                   fl2_r;
  meas_t                   ms2_r;

  assign xr = (XRS_W'(x1_r) <<< FRAC_BITS) - XRS_W'(wb1_r);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      axr2_r   <= xr[XRS_W-1] ? XR_W'(-xr) : XR_W'(xr);
      xrneg2_r <= xr[XRS_W-1];
      fux2_r   <= fux1_r;
      fvy2_r   <= fvy1_r;
      az2_r    <= az1_r;
      zsq2_r   <= zsq1_r;
      fl2_r    <= fl1_r;
      ms2_r    <= ms1_r;
    end
  end

  // stage 3: focal times |xr| in two partial products
  logic [FUX_W-1:0] prl3_r;
  logic [PRH_W-1:0] prh3_r;
  logic             xrneg3_r;
  logic [FUX_W-1:0] fux3_r, fvy3_r;
  logic [W-1:0]     az3_r;
  den_t             zsq3_r;
  flag_t            fl3_r;
  meas_t            ms3_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      prl3_r   <= FUX_W'(cfg.focal_u) * FUX_W'(axr2_r[W-1:0]);
      prh3_r   <= PRH_W'(cfg.focal_u) * PRH_W'(axr2_r[XR_W-1:W]);
      xrneg3_r <= xrneg2_r;
      fux3_r   <= fux2_r;
      fvy3_r   <= fvy2_r;
      az3_r    <= az2_r;
      zsq3_r   <= zsq2_r;
      fl3_r    <= fl2_r;
      ms3_r    <= ms2_r;
    end
  end

  // stage 4: partial products summed
  num_t             fuxr4_r;
  logic             xrneg4_r;
  logic [FUX_W-1:0] fux4_r, fvy4_r;
  logic [W-1:0]     az4_r;
  den_t             zsq4_r;
  flag_t            fl4_r;
  meas_t            ms4_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      fuxr4_r  <= NUM_W'(prl3_r) + (NUM_W'(prh3_r) << W);
      xrneg4_r <= xrneg3_r;
      fux4_r   <= fux3_r;
      fvy4_r   <= fvy3_r;
      az4_r    <= az3_r;
      zsq4_r   <= zsq3_r;
      fl4_r    <= fl3_r;
      ms4_r    <= ms3_r;
    end
  end

  // dividend and divisor of each quotient
  always_comb begin
    num_o[Q_PU]  = NUM_W'(fux4_r);
    den_o[Q_PU]  = DEN_W'(az4_r);
    num_o[Q_PV]  = NUM_W'(fvy4_r);
    den_o[Q_PV]  = DEN_W'(az4_r);
    num_o[Q_PR]  = fuxr4_r;
    den_o[Q_PR]  = DEN_W'(az4_r) << FRAC_BITS;
    num_o[Q_JFU] = NUM_W'(cfg.focal_u) << FRAC_BITS;
    den_o[Q_JFU] = DEN_W'(az4_r);
    num_o[Q_JFV] = NUM_W'(cfg.focal_v) << FRAC_BITS;
    den_o[Q_JFV] = DEN_W'(az4_r);
    num_o[Q_JLU] = NUM_W'(fux4_r) << FRAC_BITS;
    den_o[Q_JLU] = zsq4_r;
    num_o[Q_JVD] = NUM_W'(fvy4_r) << FRAC_BITS;
    den_o[Q_JVD] = zsq4_r;
    num_o[Q_JRD] = fuxr4_r;
    den_o[Q_JRD] = zsq4_r;

    side_o.meas       = ms4_r;
    side_o.zero       = fl4_r.zero;
    side_o.neg[Q_PU]  = fl4_r.xneg ^ fl4_r.zn;
    side_o.neg[Q_PV]  = fl4_r.yneg ^ fl4_r.zn;
    side_o.neg[Q_PR]  = xrneg4_r ^ fl4_r.zn;
    side_o.neg[Q_JFU] = fl4_r.zn;
    side_o.neg[Q_JFV] = fl4_r.zn;
    side_o.neg[Q_JLU] = !fl4_r.xneg;
    side_o.neg[Q_JVD] = !fl4_r.yneg;
    side_o.neg[Q_JRD] = !xrneg4_r;
  end

endmodule
`default_nettype wire

FILE: src/spej_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module spej_div import spej_pkg::*; (
  input  logic               clk,
  input  logic [DIV_STG-1:0] ld,
  input  num_t               num_i,
  input  den_t               den_i,
  output logic [QUO_W-1:0]   q_o,
  output den_t               rem_o,
  output den_t               den_o,
  output logic               ovf_o
);

  den_t             rem_r [DIV_STG];
  logic [QUO_W-1:0] sh_r  [DIV_STG];
  den_t             den_r [DIV_STG];
  logic             ovf_r [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    if (k == 0) begin : g_head
      // quotient at or above 2^QUO_W when the top part already reaches the divisor
      always_ff @(posedge clk) begin
        if (ld[0]) begin
          ovf_r[0] <= (num_i >> QUO_W) >= NUM_W'(den_i);
          rem_r[0] <= DEN_W'(num_i >> QUO_W);
          sh_r[0]  <= num_i[QUO_W-1:0];
          den_r[0] <= den_i;
        end
      end
    end else begin : g_step
      logic [DEN_W:0] r2;
      logic           ge;
      assign r2 = {rem_r[k-1], sh_r[k-1][QUO_W-1]};
      assign ge = r2 >= {1'b0, den_r[k-1]};
      always_ff @(posedge clk) begin
        if (ld[k]) begin
          rem_r[k] <= ge ? DEN_W'(r2 - {1'b0, den_r[k-1]}) : r2[DEN_W-1:0];
          sh_r[k]  <= {sh_r[k-1][QUO_W-2:0], ge};
          den_r[k] <= den_r[k-1];
          ovf_r[k] <= ovf_r[k-1];
        end
      end
    end
  end

  assign q_o   = sh_r[DIV_STG-1];
  assign rem_o = rem_r[DIV_STG-1];
  assign den_o = den_r[DIV_STG-1];
  assign ovf_o = ovf_r[DIV_STG-1];

endmodule
`default_nettype wire

FILE: src/spej_back.sv
// back stages: rounding, clamping, error sums and output register
`default_nettype none
module spej_back import spej_pkg::*; (
  input  logic                     clk,
  input  logic [BACK_STG-1:0]      ld,
  input  cfg_t                     cfg,
  input  logic [NQ-1:0][QUO_W-1:0] q_i,
  input  den_t [NQ-1:0]            rem_i,
  input  den_t [NQ-1:0]            den_i,
  input  logic [NQ-1:0]            ovf_i,
  input  side_t                    side_i,
  output logic signed [W-1:0]      err_ul,
  output logic signed [W-1:0]      err_vl,
  output logic signed [W-1:0]      err_ur,
  output logic signed [W-1:0]      err_vr,
  output logic signed [W-1:0]      jac_fu_over_z,
  output logic signed [W-1:0]      jac_fv_over_z,
  output logic signed [W-1:0]      jac_left_u_dz,
  output logic signed [W-1:0]      jac_v_dz,
  output logic signed [W-1:0]      jac_right_u_dz,
  output logic                     zero_depth
);

  localparam logic [QUO_W:0] PROJ_LIM = (QUO_W+1)'(1) << PROJ_LOG;
  localparam logic [QUO_W:0] POS_LIM  = (QUO_W+1)'(2147483647);
  localparam logic [QUO_W:0] NEG_LIM  = (QUO_W+1)'(64'd2147483648);

  // stage 1: round to nearest, ties away from zero
  logic [NQ-1:0][QUO_W:0] qr1_r;
  logic [NQ-1:0]          ovf1_r;
  side_t                  side1_r;
  logic [NQ-1:0][QUO_W:0] qr_nxt;

  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      qr_nxt[i] = (QUO_W+1)'(q_i[i]) +
                  (QUO_W+1)'({rem_i[i], 1'b0} >= {1'b0, den_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      qr1_r   <= qr_nxt;
      ovf1_r  <= ovf_i;
      side1_r <= side_i;
    end
  end

  // stage 2: clamp and sign
  logic signed [NP-1:0][PV_W-1:0]  pv2_r;
  logic signed [NQ-NP-1:0][W-1:0]  jv2_r;
  side_t                           side2_r;
  logic signed [NP-1:0][PV_W-1:0]  pv_nxt;
  logic signed [NQ-NP-1:0][W-1:0]  jv_nxt;

  always_comb begin
    logic [QUO_W:0] m;
    logic [QUO_W:0] lim;
    for (int i = 0; i < NP; i++) begin
      m = (ovf1_r[i] || qr1_r[i] > PROJ_LIM) ? PROJ_LIM : qr1_r[i];
      pv_nxt[i] = side1_r.neg[i] ? -PV_W'(m) : PV_W'(m);
    end
    for (int j = 0; j < NQ - NP; j++) begin
      lim = side1_r.neg[NP+j] ? NEG_LIM : POS_LIM;
      m = (ovf1_r[NP+j] || qr1_r[NP+j] > lim) ? lim : qr1_r[NP+j];
      jv_nxt[j] = side1_r.neg[NP+j] ? -W'(m) : W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pv2_r   <= pv_nxt;
      jv2_r   <= jv_nxt;
      side2_r <= side1_r;
    end
  end

  // stage 3: measurement minus projection, output register
  logic signed [W-1:0] e_ul, e_vl, e_ur, e_vr;

  always_comb begin
    e_ul = sat32(ERR_W'(side2_r.meas.ul) -
                 (ERR_W'($signed(pv2_r[Q_PU])) + ERR_W'(cfg.center_u)));
    e_vl = sat32(ERR_W'(side2_r.meas.vl) -
                 (ERR_W'($signed(pv2_r[Q_PV])) + ERR_W'(cfg.center_v)));
    e_ur = sat32(ERR_W'(side2_r.meas.ur) -
                 (ERR_W'($signed(pv2_r[Q_PR])) + ERR_W'(cfg.center_u)));
    e_vr = sat32(ERR_W'(side2_r.meas.vr) -
                 (ERR_W'($signed(pv2_r[Q_PV])) + ERR_W'(cfg.center_v)));
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      zero_depth <= side2_r.zero;
      if (side2_r.zero) begin
        err_ul         <= '0;
        err_vl         <= '0;
        err_ur         <= '0;
        err_vr         <= '0;
        jac_fu_over_z  <= '0;
        jac_fv_over_z  <= '0;
        jac_left_u_dz  <= '0;
        jac_v_dz       <= '0;
        jac_right_u_dz <= '0;
      end else begin
        err_ul         <= e_ul;
        err_vl         <= e_vl;
        err_ur         <= e_ur;
        err_vr         <= e_vr;
        jac_fu_over_z  <= jv2_r[Q_JFU-NP];
        jac_fv_over_z  <= jv2_r[Q_JFV-NP];
        jac_left_u_dz  <= jv2_r[Q_JLU-NP];
        jac_v_dz       <= jv2_r[Q_JVD-NP];
        jac_right_u_dz <= jv2_r[Q_JRD-NP];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/spej_checker.sv
// port-level checker for the stereo projection unit and its bind
`default_nettype none
`include "stereo_projection_error_jacobian_unit_defines.svh"
module spej_checker import spej_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [9*W-1:0]       out_tdata,
  input logic                 out_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // a waiting result keeps its word
  `SPEJ_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // zero depth words carry all-zero fields
  `SPEJ_ASSERT(a_zero_word, clk, rst_n, out_tvalid && out_tuser |-> out_tdata == '0)

  // pipeline comes out of reset empty
  `SPEJ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // an empty output lets a new word in
  `SPEJ_ASSERT(a_in_open, clk, rst_n, !out_tvalid |-> in_tready)

  // register writes are never held off
  `SPEJ_ASSERT(a_cfg_open, clk, rst_n, cfg_valid |-> cfg_ready)

endmodule

bind stereo_projection_error_jacobian_unit spej_checker u_spej_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// testbench for the stereo projection error and jacobian unit, self-checking against a predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import spej_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind this index
  localparam int LATENCY = 49;
  localparam int N_FIELDS = 9;

  typedef struct packed {
    logic [9*W-1:0] fields;
    logic           zero_depth;
  } proj_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [8*W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [9*W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0] cfg_data;

  // shadow copy of the camera registers
  logic [FOC_W-1:0] cam_fu;
  logic [FOC_W-1:0] cam_fv;
  logic signed [W-1:0] cam_cu;
  logic signed [W-1:0] cam_cv;
  logic signed [W-1:0] cam_base;

  logic [8*W-1:0] point_queue[$];
  proj_result_t expected_proj[$];
  int accepted_points;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;

  stereo_projection_error_jacobian_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // f * num / den rounded half away from zero, then clamped to the projection or 32-bit bound
  function automatic logic signed [71:0] scaled_quot(input logic [FOC_W-1:0] f,
      input logic signed [71:0] num, input logic [127:0] den, input bit den_neg,
      input bit negate, input bit proj);
    logic [71:0] mag;
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] lim;
    bit neg;
    mag = (num < 0) ? 72'(-num) : 72'(num);
    n = 128'(f) * 128'(mag);
    q = n / den;
    r = n % den;
    if (r >= den - r) q = q + 1;
    neg = ((num < 0) != den_neg) != negate;
    if (proj) lim = 128'(1) << PROJ_LOG;
    else lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -$signed(72'(q)) : $signed(72'(q));
  endfunction

  function automatic logic [W-1:0] clip32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'h7fff_ffff;
    if (v < -72'sd2147483648) return 32'h8000_0000;
    return v[W-1:0];
  endfunction

  function automatic proj_result_t project_point(input logic [8*W-1:0] word);
    proj_result_t res;
    logic signed [71:0] x2, y2, xr2, pu, pv, pr, one, xe, ye, ze, we;
    logic signed [71:0] mul, mvl, mur, mvr, cu, cv;
    logic [127:0] dproj, dsq;
    logic [71:0] az;
    bit zn;
    xe = $signed(word[0*W +: W]);
    ye = $signed(word[1*W +: W]);
    ze = $signed(word[2*W +: W]);
    we = $signed(word[3*W +: W]);
    mul = $signed(word[4*W +: W]);
    mvl = $signed(word[5*W +: W]);
    mur = $signed(word[6*W +: W]);
    mvr = $signed(word[7*W +: W]);
    cu = cam_cu;
    cv = cam_cv;
    res = '0;
    if (ze == 0) begin
      res.zero_depth = 1'b1;
      return res;
    end
    one = 72'sd1 <<< FRAC_BITS;
    x2 = xe <<< FRAC_BITS;
    y2 = ye <<< FRAC_BITS;
    xr2 = x2 - we * 72'(cam_base);
    zn = ze < 0;
    az = zn ? 72'(-ze) : 72'(ze);
    dproj = 128'(az) << FRAC_BITS;
    dsq = 128'(az) * 128'(az);
    pu = scaled_quot(cam_fu, x2, dproj, zn, 1'b0, 1'b1);
    pv = scaled_quot(cam_fv, y2, dproj, zn, 1'b0, 1'b1);
    pr = scaled_quot(cam_fu, xr2, dproj, zn, 1'b0, 1'b1);
    res.fields[0*W +: W] = clip32(mul - (pu + cu));
    res.fields[1*W +: W] = clip32(mvl - (pv + cv));
    res.fields[2*W +: W] = clip32(mur - (pr + cu));
    res.fields[3*W +: W] = clip32(mvr - (pv + cv));
    res.fields[4*W +: W] = clip32(scaled_quot(cam_fu, one, 128'(az), zn, 1'b0, 1'b0));
    res.fields[5*W +: W] = clip32(scaled_quot(cam_fv, one, 128'(az), zn, 1'b0, 1'b0));
    res.fields[6*W +: W] = clip32(scaled_quot(cam_fu, x2, dsq, 1'b0, 1'b1, 1'b0));
    res.fields[7*W +: W] = clip32(scaled_quot(cam_fv, y2, dsq, 1'b0, 1'b1, 1'b0));
    res.fields[8*W +: W] = clip32(scaled_quot(cam_fu, xr2, dsq, 1'b0, 1'b1, 1'b0));
    return res;
  endfunction

  // driver: presents queued points, predicts each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_proj.push_back(project_point(in_tdata));
        accepted_points = accepted_points + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (point_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= point_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // idle profile moves on with the number of accepted words
  always @(posedge clk) begin
    if (accepted_points < 216) begin
      send_idle_pct <= 36;
      recv_idle_pct <= 48;
    end else if (accepted_points < 432) begin
      send_idle_pct <= 48;
      recv_idle_pct <= 36;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // monitor: every output word against the oldest prediction
  always @(posedge clk) begin
    proj_result_t exp_word;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_proj.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected output word %h", out_tdata);
        end else begin
          exp_word = expected_proj.pop_front();
          for (int f = 0; f < N_FIELDS; f++) begin
            if (out_tdata[f*W +: W] !== exp_word.fields[f*W +: W]) begin
              mismatches = mismatches + 1;
              if (mismatches <= 10)
                $display("field %0d mismatch: expected %h got %h", f,
                         exp_word.fields[f*W +: W], out_tdata[f*W +: W]);
            end
          end
          if (out_tuser !== exp_word.zero_depth) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("zero_depth mismatch: expected %b got %b", exp_word.zero_depth,
                       out_tuser);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FOCAL_U:  cam_fu = value[FOC_W-1:0];
      REG_FOCAL_V:  cam_fv = value[FOC_W-1:0];
      REG_CENTER_U: cam_cu = value;
      REG_CENTER_V: cam_cv = value;
      REG_BASELINE: cam_base = value;
      default: ;
    endcase
  endtask

  task automatic load_camera(input logic [W-1:0] fu, input logic [W-1:0] fv,
      input logic [W-1:0] cu, input logic [W-1:0] cv, input logic [W-1:0] b);
    write_reg(REG_FOCAL_U, fu);
    write_reg(REG_FOCAL_V, fv);
    write_reg(REG_CENTER_U, cu);
    write_reg(REG_CENTER_V, cv);
    write_reg(REG_BASELINE, b);
  endtask

  // sender holds off until the pipe has drained completely
  task automatic drain_pipe();
    do @(negedge clk);
    while (point_queue.size() != 0 || in_tvalid || expected_proj.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_point(input logic [W-1:0] x, input logic [W-1:0] y, input logic [W-1:0] z,
      input logic [W-1:0] w, input logic [W-1:0] ul, input logic [W-1:0] vl,
      input logic [W-1:0] ur, input logic [W-1:0] vr);
    point_queue.push_back({vr, ur, vl, ul, w, z, y, x});
  endtask

  // value with a spread of magnitudes, extremes now and then
  function automatic logic [W-1:0] mixed_value();
    logic [W-1:0] v;
    int sh;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0001;
          3: v = 32'hffff_ffff;
          default: v = 32'h0001_0000;
        endcase
      end
      default: begin
        sh = $urandom_range(1, 31);
        v = $urandom >> (32 - sh);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] depth_value();
    if ($urandom_range(0, 19) == 0) return '0;
    return mixed_value();
  endfunction

  task automatic add_random_points(input int count);
    for (int i = 0; i < count; i++)
      add_point(mixed_value(), mixed_value(), depth_value(), mixed_value(),
                mixed_value(), mixed_value(), mixed_value(), mixed_value());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    accepted_points = 0;
    send_idle_pct = 36;
    recv_idle_pct = 48;
    mismatches = 0;
    cam_fu = FOCAL_ONE;
    cam_fv = FOCAL_ONE;
    cam_cu = '0;
    cam_cv = '0;
    cam_base = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed points under the reset camera
    add_point(0, 0, 0, 0, 0, 0, 0, 0);
    add_point(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(1, 1, 32'h8000_0000, 1, 0, 0, 0, 0);
    add_point(1, 32'hffff_ffff, 2, 1, 1, 1, 1, 1);
    add_point(32'hffff_ffff, 1, 32'hfffe_0000, 32'hffff_ffff, 3, 3, 3, 3);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              0, 0, 0, 0);
    drain_pipe();

    // unused index must leave the camera alone
    write_reg(REG_UNUSED, 32'hffff_ffff);
    load_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_point(32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_point(32'h0010_0000, 32'hfff0_0000, 32'h0003_0000, 32'h0001_0000, 0, 0, 0, 0);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              0, 0, 0, 0);
    add_random_points(105);
    drain_pipe();

    load_camera(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff, 0, 0, 0, 0);
    add_random_points(105);
    drain_pipe();

    load_camera(500 << 16, 480 << 16, 320 << 16, 240 << 16, $urandom_range(0, 1 << 18));
    add_random_points(105);
    drain_pipe();

    load_camera($urandom, $urandom, $urandom, $urandom, $urandom);
    add_random_points(105);
    drain_pipe();

    load_camera($urandom, $urandom, mixed_value(), mixed_value(), mixed_value());
    add_random_points(105);
    drain_pipe();

    load_camera(32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    add_random_points(105);
    drain_pipe();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/spej_pkg.sv
src/spej_cfg.sv
src/spej_front.sv
src/spej_div.sv
src/spej_back.sv
src/stereo_projection_error_jacobian_unit.sv
src/spej_checker.sv
verif/testbench.sv
